// ===== rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg: shared types and constants for the line sensor centroid core
// Sensor weights, field widths, reciprocal table and inter-stage structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

    localparam int SENSOR_COUNT = 9;
    localparam int MID_SENSOR   = 4;
    localparam int RAW_W        = 16;
    localparam int THR_W        = 8;
    localparam int WMAG_W       = 7;
    localparam int MAG_W        = 8;
    localparam int CNT_W        = 4;
    localparam int SIDE_CNT_W   = 3;
    localparam int RECIP_W      = 17;
    localparam int RECIP_SHIFT  = 16;
    localparam int PROD_W       = MAG_W + RECIP_W;
    localparam int POS_W        = 8;
    localparam int MEAN_W       = 7;

    localparam logic [THR_W-1:0] THR_RESET = 8'd69;
    localparam logic [CNT_W-1:0] ALL_COUNT = 4'd9;

    // Weight magnitudes; sensors below the center carry negative sign
    localparam logic [WMAG_W-1:0] WEIGHT_MAG [SENSOR_COUNT] =
        '{7'd70, 7'd45, 7'd37, 7'd30, 7'd0, 7'd30, 7'd37, 7'd45, 7'd70};

    typedef struct packed {
        logic mid;
        logic left;
        logic right;
        logic all;
    } lsc_flags_t;

    typedef struct packed {
        logic [MAG_W-1:0]      tot_mag;
        logic                  tot_neg;
        logic [MAG_W-1:0]      lmag;
        logic [SIDE_CNT_W-1:0] lcnt;
        logic [MAG_W-1:0]      rmag;
        logic [SIDE_CNT_W-1:0] rcnt;
        logic [CNT_W-1:0]      cnt;
        lsc_flags_t            flags;
    } lsc_sums_t;

    typedef struct packed {
        logic mul;
        logic fin;
    } lsc_en_t;

    // ceil(2^16 / d); zero divisor maps to zero so the quotient comes out 0.
    // Exact floor quotient for dividends up to 255 and divisors up to 9.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lsc_sum.sv =====
// ----------------------------------------------------------------------------
// lsc_sum: sensor decode and side sums
// First pipeline stage: active-low decode, per-side weight sums and counts,
// signed total as sign/magnitude, and the four flags.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_sum (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [lsc_pkg::RAW_W-1:0]   raw_word,
    input  wire logic [lsc_pkg::THR_W-1:0]   thr,
    output lsc_pkg::lsc_sums_t               sums
);

    lsc_pkg::lsc_sums_t sums_reg;
    lsc_pkg::lsc_sums_t sums_next;

    // Decode and accumulate
    always_comb
    begin
        logic [lsc_pkg::SENSOR_COUNT-1:0] act;
        logic [lsc_pkg::MAG_W-1:0]        lmag;
        logic [lsc_pkg::MAG_W-1:0]        rmag;
        logic [lsc_pkg::SIDE_CNT_W-1:0]   lcnt;
        logic [lsc_pkg::SIDE_CNT_W-1:0]   rcnt;
        logic                             neg;
        lmag = '0;
        rmag = '0;
        lcnt = '0;
        rcnt = '0;
        for (int i = 0; i < lsc_pkg::SENSOR_COUNT; i++)
        begin
            act[i] = ~raw_word[lsc_pkg::RAW_W-1-i];
        end
        for (int i = lsc_pkg::MID_SENSOR + 1; i < lsc_pkg::SENSOR_COUNT; i++)
        begin
            if (act[i])
            begin
                lmag = lmag + {1'b0, lsc_pkg::WEIGHT_MAG[i]};
                lcnt = lcnt + 1'b1;
            end
        end
        for (int i = 0; i < lsc_pkg::MID_SENSOR; i++)
        begin
            if (act[i])
            begin
                rmag = rmag + {1'b0, lsc_pkg::WEIGHT_MAG[i]};
                rcnt = rcnt + 1'b1;
            end
        end
        neg = (rmag > lmag);
        sums_next.tot_neg     = neg;
        sums_next.tot_mag     = neg ? (rmag - lmag) : (lmag - rmag);
        sums_next.lmag        = lmag;
        sums_next.lcnt        = lcnt;
        sums_next.rmag        = rmag;
        sums_next.rcnt        = rcnt;
        sums_next.cnt         = {1'b0, lcnt} + {1'b0, rcnt}
                                + {3'b000, act[lsc_pkg::MID_SENSOR]};
        sums_next.flags.mid   = act[lsc_pkg::MID_SENSOR];
        sums_next.flags.left  = (lmag > thr);
        sums_next.flags.right = (rmag > thr);
        sums_next.flags.all   = &act;
    end

    // Stage register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sums_reg <= sums_next;
        end
    end

    assign sums = sums_reg;

endmodule

`default_nettype wire

// ===== rtl/lsc_div.sv =====
// ----------------------------------------------------------------------------
// lsc_div: two-stage small divider
// Truncating sign/magnitude divide by 0..9 through a reciprocal multiply;
// stage one registers the product, stage two scales and applies the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_div (
    input  wire logic                              clk,
    input  wire lsc_pkg::lsc_en_t                  en,
    input  wire logic [lsc_pkg::MAG_W-1:0]         mag,
    input  wire logic [lsc_pkg::CNT_W-1:0]         den,
    input  wire logic                              neg,
    output logic signed [lsc_pkg::POS_W-1:0]       quot
);

    logic [lsc_pkg::PROD_W-1:0]       prod_reg;
    logic [lsc_pkg::PROD_W-1:0]       prod_next;
    logic                             neg_reg;
    logic [lsc_pkg::MAG_W-1:0]        q_mag;
    logic signed [lsc_pkg::POS_W-1:0] quot_reg;
    logic signed [lsc_pkg::POS_W-1:0] quot_next;

    // Reciprocal multiply
    assign prod_next = {{lsc_pkg::RECIP_W{1'b0}}, mag} *
                       {{lsc_pkg::MAG_W{1'b0}}, lsc_pkg::recip(den)};

    // Scale down and restore sign
    assign q_mag     = prod_reg[lsc_pkg::RECIP_SHIFT +: lsc_pkg::MAG_W];
    assign quot_next = neg_reg ? -$signed(q_mag) : $signed(q_mag);

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_reg <= prod_next;
            neg_reg  <= neg;
        end
        if (en.fin)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/line_sensor_centroid_core.sv =====
// ----------------------------------------------------------------------------
// line_sensor_centroid_core: weighted centroid of nine line sensors
// Position, per-side mean weights, active count and branch flags per sample.
// ----------------------------------------------------------------------------
// One sample enters per clock unless all stages are full and the output is
// stalled; the three register stages are sensor decode and summing,
// reciprocal multiply, and quotient scaling with sign. Each stage holds its
// item independently, so a stalled output only stops stages that are full.
// The threshold register is sampled in the first stage.
`default_nettype none

module line_sensor_centroid_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [lsc_pkg::THR_W-1:0]         cfg_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [lsc_pkg::RAW_W-1:0]         raw_word,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [lsc_pkg::POS_W-1:0]       position,
    output logic [lsc_pkg::MEAN_W-1:0]             left_mean,
    output logic [lsc_pkg::MEAN_W-1:0]             right_mean,
    output logic [lsc_pkg::CNT_W-1:0]              active_count,
    output logic                                   mid_flag,
    output logic                                   left_flag,
    output logic                                   right_flag,
    output logic                                   all_flag
);

    logic [lsc_pkg::THR_W-1:0] thr_reg;
    logic                      v1_reg, v2_reg, v3_reg;
    logic                      rdy1, rdy2, rdy3;
    lsc_pkg::lsc_sums_t        sums;
    lsc_pkg::lsc_en_t          div_en;
    logic [lsc_pkg::CNT_W-1:0] cnt2_reg, cnt3_reg;
    lsc_pkg::lsc_flags_t       flags2_reg, flags3_reg;
    logic signed [lsc_pkg::POS_W-1:0] pos_q, left_q, right_q;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= lsc_pkg::THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Per-stage ready: a stage loads when empty or when its item moves on
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1: decode and sums
    lsc_sum u_sum (
        .clk      (clk),
        .en       (rdy1),
        .raw_word (raw_word),
        .thr      (thr_reg),
        .sums     (sums)
    );

    // Stages 2 and 3: three dividers in lockstep
    assign div_en.mul = rdy2;
    assign div_en.fin = rdy3;

    lsc_div u_div_pos (
        .clk  (clk),
        .en   (div_en),
        .mag  (sums.tot_mag),
        .den  (sums.cnt),
        .neg  (sums.tot_neg),
        .quot (pos_q)
    );

    lsc_div u_div_left (
        .clk  (clk),
        .en   (div_en),
        .mag  (sums.lmag),
        .den  ({1'b0, sums.lcnt}),
        .neg  (1'b0),
        .quot (left_q)
    );

    lsc_div u_div_right (
        .clk  (clk),
        .en   (div_en),
        .mag  (sums.rmag),
        .den  ({1'b0, sums.rcnt}),
        .neg  (1'b0),
        .quot (right_q)
    );

    // Count and flags ride alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            cnt2_reg   <= sums.cnt;
            flags2_reg <= sums.flags;
        end
        if (rdy3)
        begin
            cnt3_reg   <= cnt2_reg;
            flags3_reg <= flags2_reg;
        end
    end

    assign out_valid    = v3_reg;
    assign position     = pos_q;
    assign left_mean    = left_q[lsc_pkg::MEAN_W-1:0];
    assign right_mean   = right_q[lsc_pkg::MEAN_W-1:0];
    assign active_count = cnt3_reg;
    assign mid_flag     = flags3_reg.mid;
    assign left_flag    = flags3_reg.left;
    assign right_flag   = flags3_reg.right;
    assign all_flag     = flags3_reg.all;

`ifndef SYNTHESIS
    // Input only blocks when every stage is full and the output is stalled
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && !out_ready))
        else $error("input stalled with a free stage");

    // Crossing flag agrees with the count
    a_all_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && all_flag) |-> (active_count == lsc_pkg::ALL_COUNT))
        else $error("all_flag without nine active sensors");

    // Nothing active gives zero position and means and no center flag
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && active_count == '0) |->
        (position == '0 && left_mean == '0 && right_mean == '0 && !mid_flag))
        else $error("nonzero result with no active sensor");

    // Center flag implies at least one active sensor
    a_mid_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mid_flag) |-> (active_count != '0))
        else $error("mid_flag with zero count");
`endif

endmodule

`default_nettype wire

// ===== bench/lsc_centroid_checker.sv =====
// ----------------------------------------------------------------------------
// lsc_centroid_checker: result checker for the line sensor centroid core
// Watches both channels and the threshold port, predicts each sample's
// centroid, side means, count and flags, and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lsc_centroid_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [lsc_pkg::THR_W-1:0]           cfg_wr_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [lsc_pkg::RAW_W-1:0]           raw_word,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [lsc_pkg::POS_W-1:0]    position,
    input  logic [lsc_pkg::MEAN_W-1:0]          left_mean,
    input  logic [lsc_pkg::MEAN_W-1:0]          right_mean,
    input  logic [lsc_pkg::CNT_W-1:0]           active_count,
    input  logic                                mid_flag,
    input  logic                                left_flag,
    input  logic                                right_flag,
    input  logic                                all_flag,
    output int                                  pending_results,
    output int                                  fail_count
);

    localparam int REPORT_LIMIT = 10;

    // Signed sensor weights, sensor 0 on the far right
    localparam int SENSOR_WEIGHT [lsc_pkg::SENSOR_COUNT] =
        '{-70, -45, -37, -30, 0, 30, 37, 45, 70};

    typedef struct packed {
        logic signed [lsc_pkg::POS_W-1:0] position;
        logic [lsc_pkg::MEAN_W-1:0]       left_mean;
        logic [lsc_pkg::MEAN_W-1:0]       right_mean;
        logic [lsc_pkg::CNT_W-1:0]        active_count;
        logic                             mid_flag;
        logic                             left_flag;
        logic                             right_flag;
        logic                             all_flag;
    } centroid_t;

    centroid_t                  centroid_q [$];
    centroid_t                  got;
    centroid_t                  want;
    logic [lsc_pkg::THR_W-1:0]  threshold;
    int                         errors;

    // Centroid of one reading; a zero sensor bit is an active sensor,
    // empty groups give a zero mean, quotients truncate toward zero
    function automatic centroid_t predict_centroid(
        input logic [lsc_pkg::RAW_W-1:0] word,
        input logic [lsc_pkg::THR_W-1:0] thr
    );
        centroid_t r;
        int        total;
        int        lsum;
        int        rsum;
        int        cnt;
        int        lcnt;
        int        rcnt;
        int        i;
        r     = '0;
        total = 0;
        lsum  = 0;
        rsum  = 0;
        cnt   = 0;
        lcnt  = 0;
        rcnt  = 0;
        for (i = 0; i < lsc_pkg::SENSOR_COUNT; i++)
        begin
            if (!word[lsc_pkg::RAW_W-1-i])
            begin
                cnt++;
                total += SENSOR_WEIGHT[i];
                if (i > lsc_pkg::MID_SENSOR)
                begin
                    lcnt++;
                    lsum += SENSOR_WEIGHT[i];
                end
                else if (i < lsc_pkg::MID_SENSOR)
                begin
                    rcnt++;
                    rsum += SENSOR_WEIGHT[i];
                end
                else
                    r.mid_flag = 1'b1;
            end
        end
        if (cnt != 0)
            r.position = lsc_pkg::POS_W'(total / cnt);
        if (lcnt != 0)
            r.left_mean = lsc_pkg::MEAN_W'(lsum / lcnt);
        if (rcnt != 0)
            r.right_mean = lsc_pkg::MEAN_W'((-rsum) / rcnt);
        r.active_count = lsc_pkg::CNT_W'(cnt);
        r.left_flag    = lsum > int'(thr);
        r.right_flag   = rsum < -int'(thr);
        r.all_flag     = cnt == lsc_pkg::SENSOR_COUNT;
        return r;
    endfunction

    // Track threshold, queue predictions on input transfers,
    // compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centroid_q.delete();
            errors          = 0;
            threshold       <= lsc_pkg::THR_RESET;
            pending_results <= 0;
            fail_count      <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {position, left_mean, right_mean, active_count,
                       mid_flag, left_flag, right_flag, all_flag};
                if (centroid_q.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: result with none expected: pos=%0d lmean=%0d rmean=%0d cnt=%0d mlra=%b%b%b%b",
                                 $realtime, got.position, got.left_mean, got.right_mean,
                                 got.active_count, got.mid_flag, got.left_flag,
                                 got.right_flag, got.all_flag);
                end
                else
                begin
                    want = centroid_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected pos=%0d lmean=%0d rmean=%0d cnt=%0d mlra=%b%b%b%b",
                                     want.position, want.left_mean, want.right_mean,
                                     want.active_count, want.mid_flag, want.left_flag,
                                     want.right_flag, want.all_flag);
                            $display("  actual   pos=%0d lmean=%0d rmean=%0d cnt=%0d mlra=%b%b%b%b",
                                     got.position, got.left_mean, got.right_mean,
                                     got.active_count, got.mid_flag, got.left_flag,
                                     got.right_flag, got.all_flag);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                centroid_q.push_back(predict_centroid(raw_word, threshold));
            if (cfg_wr_en)
                threshold <= cfg_wr_data;
            pending_results <= centroid_q.size();
            fail_count      <= errors;
        end
    end

endmodule

// ===== bench/line_sensor_centroid_core_tb.sv =====
// ----------------------------------------------------------------------------
// line_sensor_centroid_core_tb: testbench for the line sensor centroid core
// Directed sensor patterns, then random readings over several thresholds,
// with random gaps on both channels; a side checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module line_sensor_centroid_core_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int BLOCK_ITEMS  = 105;
    localparam int BLOCK_COUNT  = 6;
    localparam int DRAIN_CYCLES = 10;

    // Directed readings: none/all active, ignored low bits, each single
    // sensor, one side only, branch thresholds, truncation of negatives
    localparam logic [15:0] DIRECTED_WORDS [22] = '{
        16'hFFFF, 16'h0000, 16'h007F, 16'hFF80,
        16'h7FFF, 16'hBFFF, 16'hDFFF, 16'hEFFF, 16'hF7FF,
        16'hFBFF, 16'hFDFF, 16'hFEFF, 16'hFF7F,
        16'hF87F, 16'h0FFF, 16'hF9FF, 16'h3FFF,
        16'h5555, 16'hAAAA, 16'h7F7F, 16'hE7FF, 16'h6BFF
    };

    // Threshold per random block; zero marks a random value, except in the first block
    localparam logic [7:0] BLOCK_THRESHOLD [BLOCK_COUNT] =
        '{8'd0, 8'd255, 8'd70, 8'd0, 8'd37, 8'd0};

    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               cfg_wr_en    = 1'b0;
    logic [lsc_pkg::THR_W-1:0]          cfg_wr_data  = '0;
    logic                               in_valid     = 1'b0;
    logic [lsc_pkg::RAW_W-1:0]          raw_word     = '0;
    logic                               out_ready    = 1'b0;
    logic                               in_ready;
    logic                               out_valid;
    logic signed [lsc_pkg::POS_W-1:0]   position;
    logic [lsc_pkg::MEAN_W-1:0]         left_mean;
    logic [lsc_pkg::MEAN_W-1:0]         right_mean;
    logic [lsc_pkg::CNT_W-1:0]          active_count;
    logic                               mid_flag;
    logic                               left_flag;
    logic                               right_flag;
    logic                               all_flag;
    int                                 pending_results;
    int                                 fail_count;
    int                                 send_idle_pct = 0;
    int                                 recv_idle_pct = 0;
    int                                 cycle_count   = 0;

    line_sensor_centroid_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .raw_word     (raw_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .position     (position),
        .left_mean    (left_mean),
        .right_mean   (right_mean),
        .active_count (active_count),
        .mid_flag     (mid_flag),
        .left_flag    (left_flag),
        .right_flag   (right_flag),
        .all_flag     (all_flag)
    );

    lsc_centroid_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .raw_word        (raw_word),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .position        (position),
        .left_mean       (left_mean),
        .right_mean      (right_mean),
        .active_count    (active_count),
        .mid_flag        (mid_flag),
        .left_flag       (left_flag),
        .right_flag      (right_flag),
        .all_flag        (all_flag),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one reading after a random gap; returns in the step of its transfer
    task automatic send_reading(input logic [lsc_pkg::RAW_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_word <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [lsc_pkg::THR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random reading biased toward crossings, lost line, single sensors
    // and one-sided patterns; low bits always random
    function automatic logic [lsc_pkg::RAW_W-1:0] random_reading();
        logic [lsc_pkg::RAW_W-1:0] word;
        word = lsc_pkg::RAW_W'($urandom);
        case ($urandom_range(9))
            0: word[15:7] = '0;
            1: word[15:7] = '1;
            2: word[15:7] = ~(9'b1 << $urandom_range(8));
            3: word[15:11] = '1;
            4: word[11:7] = '1;
            default: ;
        endcase
        return word;
    endfunction

    // Stimulus and verdict
    initial
    begin
        int blk;
        int n;
        send_idle_pct = 17;
        recv_idle_pct = 65;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed patterns at the reset threshold
        foreach (DIRECTED_WORDS[k])
            send_reading(DIRECTED_WORDS[k]);

        // random blocks, one threshold each
        for (blk = 0; blk < BLOCK_COUNT; blk++)
        begin
            if (blk == 2)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 17;
            end
            else if (blk == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_for_drain();
            if (BLOCK_THRESHOLD[blk] == 8'd0 && blk != 0)
                write_threshold(lsc_pkg::THR_W'($urandom_range(255)));
            else
                write_threshold(BLOCK_THRESHOLD[blk]);
            for (n = 0; n < BLOCK_ITEMS; n++)
            begin
                // let the pipeline run empty once mid-stream
                if (blk == 1 && n == BLOCK_ITEMS / 2)
                    wait_for_drain();
                send_reading(random_reading());
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
